// ----- rtl/irc_pkg.sv -----
`default_nettype none
package irc_pkg;

   localparam int SLOT_COUNT_DEF  = 64;
   localparam int INODE_COUNT_DEF = 1024;
   localparam int REF_BITS_DEF    = 8;

   typedef enum logic [1:0] {
      OP_GET   = 2'd0,
      OP_PUT   = 2'd1,
      OP_ALLOC = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_INODE = 2'd1,
      ST_NO_SLOT  = 2'd2,
      ST_IGNORED  = 2'd3
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/irc_req_if.sv -----
`default_nettype none
interface irc_req_if #(
   parameter int SLOT_COUNT  = irc_pkg::SLOT_COUNT_DEF,
   parameter int INODE_COUNT = irc_pkg::INODE_COUNT_DEF
);
   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int INO_W  = $clog2(INODE_COUNT);

   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [INO_W-1:0]  inode_number;
   logic [SLOT_W-1:0] slot_index;

   modport source (output valid, opcode, inode_number, slot_index, input ready);
   modport sink   (input valid, opcode, inode_number, slot_index, output ready);
endinterface
`default_nettype wire

// ----- rtl/irc_rsp_if.sv -----
`default_nettype none
interface irc_rsp_if #(
   parameter int SLOT_COUNT  = irc_pkg::SLOT_COUNT_DEF,
   parameter int INODE_COUNT = irc_pkg::INODE_COUNT_DEF,
   parameter int REF_BITS    = irc_pkg::REF_BITS_DEF
);
   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int INO_W  = $clog2(INODE_COUNT);

   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [SLOT_W-1:0]   result_slot;
   logic [INO_W-1:0]    result_inode;
   logic [REF_BITS-1:0] result_refs;
   logic                fetch_needed;
   logic                write_back;
   logic                fresh_inode;

   modport source (output valid, status, result_slot, result_inode, result_refs,
                   fetch_needed, write_back, fresh_inode, input ready);
   modport sink   (input valid, status, result_slot, result_inode, result_refs,
                   fetch_needed, write_back, fresh_inode, output ready);
endinterface
`default_nettype wire

// ----- rtl/inode_refcount_cache.sv -----
// get and allocate: full slot table scan through the registered slot memory read port,
//    then the hit or free slot is written; put: read, check and write back one slot
// bad slot, unused opcode, inodes exhausted: no slot access; one item at a time
// a held result does not block the next item, only the issue of the next result; the
//    output register parts the two sides
// after reset the slot memory is cleared slot by slot with req ready low
`default_nettype none
module inode_refcount_cache #(
   parameter int SLOT_COUNT  = irc_pkg::SLOT_COUNT_DEF,
   parameter int INODE_COUNT = irc_pkg::INODE_COUNT_DEF,
   parameter int REF_BITS    = irc_pkg::REF_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   irc_req_if.sink   req_ch,
   irc_rsp_if.source rsp_ch
);
   localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int INO_W   = $clog2(INODE_COUNT);
   localparam int CNT_W   = $clog2(INODE_COUNT + 1);
   localparam int ENTRY_W = INO_W + REF_BITS;
   localparam logic [SLOT_W-1:0]   LastSlot   = SLOT_W'(SLOT_COUNT - 1);
   localparam logic [CNT_W-1:0]    InodeLimit = CNT_W'(INODE_COUNT);
   localparam logic [REF_BITS-1:0] RefMax     = '1;
   localparam logic [REF_BITS-1:0] RefOne     = REF_BITS'(1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_SCAN_END, S_DECIDE, S_PUT_RD, S_PUT_CHK, S_RESP
   } state_type;

   // slot memory, entry = {inode, refs}
   logic [ENTRY_W-1:0] slot_mem [SLOT_COUNT];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               mem_we;
   logic [SLOT_W-1:0]  mem_wa;
   logic [ENTRY_W-1:0] mem_wd;
   logic [SLOT_W-1:0]  mem_ra;
   logic [INO_W-1:0]   rd_inode;
   logic [REF_BITS-1:0] rd_refs;

   state_type state_ff, state_in;
   logic [SLOT_W-1:0]   ptr_ff, ptr_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]    alloc_cnt_ff, alloc_cnt_in;
   logic                is_alloc_ff, is_alloc_in;
   logic [INO_W-1:0]    ino_ff, ino_in;
   logic [SLOT_W-1:0]   sidx_ff, sidx_in;
   logic                hit_found_ff, hit_found_in;
   logic [SLOT_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [REF_BITS-1:0] hit_refs_ff, hit_refs_in;
   logic                free_found_ff, free_found_in;
   logic [SLOT_W-1:0]   free_idx_ff, free_idx_in;
   logic [REF_BITS-1:0] hit_refs_inc;

   irc_pkg::status_type res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [INO_W-1:0]    res_inode_ff, res_inode_in;
   logic [REF_BITS-1:0] res_refs_ff, res_refs_in;
   logic                res_fetch_ff, res_fetch_in;
   logic                res_wb_ff, res_wb_in;
   logic                res_fresh_ff, res_fresh_in;

   logic                rsp_valid_ff, rsp_valid_in;
   irc_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [INO_W-1:0]    rsp_inode_ff, rsp_inode_in;
   logic [REF_BITS-1:0] rsp_refs_ff, rsp_refs_in;
   logic                rsp_fetch_ff, rsp_fetch_in;
   logic                rsp_wb_ff, rsp_wb_in;
   logic                rsp_fresh_ff, rsp_fresh_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= slot_mem[mem_ra];
   end

   assign rd_inode = rd_data_ff[ENTRY_W-1:REF_BITS];
   assign rd_refs  = rd_data_ff[REF_BITS-1:0];
   assign mem_ra   = (state_ff == S_PUT_RD) ? sidx_ff : ptr_ff;
   assign hit_refs_inc = (hit_refs_ff == RefMax) ? hit_refs_ff : hit_refs_ff + RefOne;

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.result_slot  = rsp_slot_ff;
   assign rsp_ch.result_inode = rsp_inode_ff;
   assign rsp_ch.result_refs  = rsp_refs_ff;
   assign rsp_ch.fetch_needed = rsp_fetch_ff;
   assign rsp_ch.write_back   = rsp_wb_ff;
   assign rsp_ch.fresh_inode  = rsp_fresh_ff;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      alloc_cnt_in  = alloc_cnt_ff;
      is_alloc_in   = is_alloc_ff;
      ino_in        = ino_ff;
      sidx_in       = sidx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_refs_in   = hit_refs_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_inode_in  = res_inode_ff;
      res_refs_in   = res_refs_ff;
      res_fetch_in  = res_fetch_ff;
      res_wb_in     = res_wb_ff;
      res_fresh_in  = res_fresh_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_inode_in  = rsp_inode_ff;
      rsp_refs_in   = rsp_refs_ff;
      rsp_fetch_in  = rsp_fetch_ff;
      rsp_wb_in     = rsp_wb_ff;
      rsp_fresh_in  = rsp_fresh_ff;
      mem_we        = 1'b0;
      mem_wa        = ptr_ff;
      mem_wd        = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // scan data of the slot read in the cycle before, lowest index wins
      if (chk_vld_ff) begin
         if (rd_refs != '0 && rd_inode == ino_ff && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = chk_idx_ff;
            hit_refs_in  = rd_refs;
         end
         if (rd_refs == '0 && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = chk_idx_ff;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            if (ptr_ff == LastSlot) begin
               ptr_in   = '0;
               state_in = S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               ino_in        = req_ch.inode_number;
               sidx_in       = req_ch.slot_index;
               is_alloc_in   = 1'b0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               ptr_in        = '0;
               res_status_in = irc_pkg::ST_OK;
               res_slot_in   = '0;
               res_inode_in  = '0;
               res_refs_in   = '0;
               res_fetch_in  = 1'b0;
               res_wb_in     = 1'b0;
               res_fresh_in  = 1'b0;
               case (req_ch.opcode)
                  irc_pkg::OP_GET: begin
                     state_in = S_SCAN;
                  end
                  irc_pkg::OP_PUT: begin
                     if (req_ch.slot_index > LastSlot) begin
                        res_status_in = irc_pkg::ST_IGNORED;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_PUT_RD;
                     end
                  end
                  irc_pkg::OP_ALLOC: begin
                     // the used map only ever fills from the bottom, so a count stands for it
                     if (alloc_cnt_ff == InodeLimit) begin
                        res_status_in = irc_pkg::ST_NO_INODE;
                        state_in      = S_RESP;
                     end else begin
                        ino_in       = alloc_cnt_ff[INO_W-1:0];
                        alloc_cnt_in = alloc_cnt_ff + 1'b1;
                        is_alloc_in  = 1'b1;
                        state_in     = S_SCAN;
                     end
                  end
                  default: begin
                     res_status_in = irc_pkg::ST_IGNORED;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            chk_vld_in = 1'b1;
            chk_idx_in = ptr_ff;
            if (ptr_ff == LastSlot) begin
               state_in = S_SCAN_END;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_SCAN_END: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_RESP;
            if (hit_found_ff) begin
               mem_we       = 1'b1;
               mem_wa       = hit_idx_ff;
               mem_wd       = {ino_ff, hit_refs_inc};
               res_slot_in  = hit_idx_ff;
               res_inode_in = ino_ff;
               res_refs_in  = hit_refs_inc;
               res_wb_in    = is_alloc_ff;
               res_fresh_in = is_alloc_ff;
            end else if (free_found_ff) begin
               mem_we       = 1'b1;
               mem_wa       = free_idx_ff;
               mem_wd       = {ino_ff, RefOne};
               res_slot_in  = free_idx_ff;
               res_inode_in = ino_ff;
               res_refs_in  = RefOne;
               res_fetch_in = !is_alloc_ff;
               res_wb_in    = is_alloc_ff;
               res_fresh_in = is_alloc_ff;
            end else begin
               res_status_in = irc_pkg::ST_NO_SLOT;
            end
         end
         S_PUT_RD: begin
            state_in = S_PUT_CHK;
         end
         S_PUT_CHK: begin
            state_in     = S_RESP;
            res_slot_in  = sidx_ff;
            res_inode_in = rd_inode;
            if (rd_refs == '0) begin
               res_status_in = irc_pkg::ST_IGNORED;
            end else begin
               mem_we      = 1'b1;
               mem_wa      = sidx_ff;
               mem_wd      = {rd_inode, rd_refs - RefOne};
               res_refs_in = rd_refs - RefOne;
               res_wb_in   = (rd_refs == RefOne);
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_inode_in  = res_inode_ff;
               rsp_refs_in   = res_refs_ff;
               rsp_fetch_in  = res_fetch_ff;
               rsp_wb_in     = res_wb_ff;
               rsp_fresh_in  = res_fresh_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ptr_ff        <= '0;
         chk_vld_ff    <= 1'b0;
         alloc_cnt_ff  <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         chk_vld_ff    <= chk_vld_in;
         alloc_cnt_ff  <= alloc_cnt_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      chk_idx_ff    <= chk_idx_in;
      is_alloc_ff   <= is_alloc_in;
      ino_ff        <= ino_in;
      sidx_ff       <= sidx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_refs_ff   <= hit_refs_in;
      free_idx_ff   <= free_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_inode_ff  <= res_inode_in;
      res_refs_ff   <= res_refs_in;
      res_fetch_ff  <= res_fetch_in;
      res_wb_ff     <= res_wb_in;
      res_fresh_ff  <= res_fresh_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_inode_ff  <= rsp_inode_in;
      rsp_refs_ff   <= rsp_refs_in;
      rsp_fetch_ff  <= rsp_fetch_in;
      rsp_wb_ff     <= rsp_wb_in;
      rsp_fresh_ff  <= rsp_fresh_in;
   end

endmodule
`default_nettype wire

// ----- rtl/irc_checker.sv -----
`default_nettype none
module irc_checker #(
   parameter int SLOT_COUNT  = irc_pkg::SLOT_COUNT_DEF,
   parameter int INODE_COUNT = irc_pkg::INODE_COUNT_DEF,
   parameter int REF_BITS    = irc_pkg::REF_BITS_DEF
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [1:0]           rsp_status,
   input wire logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] rsp_slot,
   input wire logic [$clog2(INODE_COUNT)-1:0] rsp_inode,
   input wire logic [REF_BITS-1:0]  rsp_refs,
   input wire logic                 rsp_fetch,
   input wire logic                 rsp_wb,
   input wire logic                 rsp_fresh
);

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_refs)
         && $stable(rsp_status))
      else $error("held result changed");

   // one item at a time: no accept in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // no free slot reports all fields and flags zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == irc_pkg::ST_NO_SLOT |->
         rsp_slot == '0 && rsp_inode == '0 && rsp_refs == '0
         && !rsp_fetch && !rsp_wb && !rsp_fresh)
      else $error("no free slot with nonzero fields");

   // a fetch comes only from a newly claimed slot of a get
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fetch |->
         rsp_status == irc_pkg::ST_OK && rsp_refs == REF_BITS'(1) && !rsp_wb && !rsp_fresh)
      else $error("bad fetch result");

   // a fresh inode is always flagged for write-back and is live
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fresh |-> rsp_status == irc_pkg::ST_OK && rsp_wb && rsp_refs != '0)
      else $error("bad fresh result");

endmodule

bind inode_refcount_cache irc_checker #(
   .SLOT_COUNT  (SLOT_COUNT),
   .INODE_COUNT (INODE_COUNT),
   .REF_BITS    (REF_BITS)
) u_irc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_slot   (rsp_ch.result_slot),
   .rsp_inode  (rsp_ch.result_inode),
   .rsp_refs   (rsp_ch.result_refs),
   .rsp_fetch  (rsp_ch.fetch_needed),
   .rsp_wb     (rsp_ch.write_back),
   .rsp_fresh  (rsp_ch.fresh_inode)
);
`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none
module testbench;

   localparam int SLOTS    = irc_pkg::SLOT_COUNT_DEF;
   localparam int INODES   = irc_pkg::INODE_COUNT_DEF;
   localparam int REF_BITS = irc_pkg::REF_BITS_DEF;
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int INO_W    = $clog2(INODES);
   localparam int REF_MAX  = (1 << REF_BITS) - 1;

   // opcode 3 is not decoded by the block
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      irc_pkg::status_type status;
      logic [SLOT_W-1:0]   slot;
      logic [INO_W-1:0]    inode;
      logic [REF_BITS-1:0] refs;
      logic                fetch;
      logic                wb;
      logic                fresh;
   } reply_type;

   localparam reply_type BLANK_REPLY = '{irc_pkg::ST_OK, '0, '0, '0, 1'b0, 1'b0, 1'b0};

   typedef struct {
      logic [1:0]        op;
      logic [INO_W-1:0]  ino;
      int                ino_step;
      logic [SLOT_W-1:0] sidx;
      int                reps;
      bit                typed;
      reply_type         want;
   } plan_row_type;

   localparam int N_ROWS = 19;

   // op, inode, inode step, slot, repeats, typed, expected item
   plan_row_type plan [N_ROWS] = '{
      '{irc_pkg::OP_PUT,   10'd0,    0, 6'd0,   1, 1'b1,
        '{irc_pkg::ST_IGNORED, 6'd0,  10'd0,    8'd0,   1'b0, 1'b0, 1'b0}},
      '{OP_UNUSED,         10'd1023, 0, 6'd63,  1, 1'b1,
        '{irc_pkg::ST_IGNORED, 6'd0,  10'd0,    8'd0,   1'b0, 1'b0, 1'b0}},
      '{irc_pkg::OP_GET,   10'd0,    0, 6'd63,  1, 1'b1,
        '{irc_pkg::ST_OK,      6'd0,  10'd0,    8'd1,   1'b1, 1'b0, 1'b0}},
      '{irc_pkg::OP_GET,   10'd1023, 0, 6'd0,   1, 1'b1,
        '{irc_pkg::ST_OK,      6'd1,  10'd1023, 8'd1,   1'b1, 1'b0, 1'b0}},
      '{irc_pkg::OP_GET,   10'd0,    0, 6'd0,   1, 1'b1,
        '{irc_pkg::ST_OK,      6'd0,  10'd0,    8'd2,   1'b0, 1'b0, 1'b0}},
      '{irc_pkg::OP_PUT,   10'd0,    0, 6'd1,   1, 1'b1,
        '{irc_pkg::ST_OK,      6'd1,  10'd1023, 8'd0,   1'b0, 1'b1, 1'b0}},
      // released slot keeps its stale inode number
      '{irc_pkg::OP_PUT,   10'd0,    0, 6'd1,   1, 1'b1,
        '{irc_pkg::ST_IGNORED, 6'd1,  10'd1023, 8'd0,   1'b0, 1'b0, 1'b0}},
      // stale slot must not count as a hit
      '{irc_pkg::OP_GET,   10'd1023, 0, 6'd0,   1, 1'b1,
        '{irc_pkg::ST_OK,      6'd1,  10'd1023, 8'd1,   1'b1, 1'b0, 1'b0}},
      // inode 0 is already cached, so the alloc bumps slot 0
      '{irc_pkg::OP_ALLOC, 10'd0,    0, 6'd0,   1, 1'b1,
        '{irc_pkg::ST_OK,      6'd0,  10'd0,    8'd3,   1'b0, 1'b1, 1'b1}},
      '{irc_pkg::OP_ALLOC, 10'd0,    0, 6'd0,   1, 1'b1,
        '{irc_pkg::ST_OK,      6'd2,  10'd1,    8'd1,   1'b0, 1'b1, 1'b1}},
      // drive slot 0 into saturation
      '{irc_pkg::OP_GET,   10'd0,    0, 6'd0, 260, 1'b0, BLANK_REPLY},
      '{irc_pkg::OP_PUT,   10'd0,    0, 6'd63,  1, 1'b1,
        '{irc_pkg::ST_IGNORED, 6'd63, 10'd0,    8'd0,   1'b0, 1'b0, 1'b0}},
      // fill every remaining slot
      '{irc_pkg::OP_GET,   10'd512,  1, 6'd0,  61, 1'b0, BLANK_REPLY},
      '{irc_pkg::OP_GET,   10'd1000, 0, 6'd0,   1, 1'b1,
        '{irc_pkg::ST_NO_SLOT, 6'd0,  10'd0,    8'd0,   1'b0, 1'b0, 1'b0}},
      // inode 2 is used up even though no slot takes it
      '{irc_pkg::OP_ALLOC, 10'd0,    0, 6'd0,   1, 1'b1,
        '{irc_pkg::ST_NO_SLOT, 6'd0,  10'd0,    8'd0,   1'b0, 1'b0, 1'b0}},
      '{irc_pkg::OP_PUT,   10'd0,    0, 6'd40,  1, 1'b0, BLANK_REPLY},
      '{irc_pkg::OP_ALLOC, 10'd0,    0, 6'd0,   1, 1'b1,
        '{irc_pkg::ST_OK,      6'd40, 10'd3,    8'd1,   1'b0, 1'b1, 1'b1}},
      '{irc_pkg::OP_GET,   10'd0,    0, 6'd0,   1, 1'b1,
        '{irc_pkg::ST_OK,      6'd0,  10'd0,    8'd255, 1'b0, 1'b0, 1'b0}},
      '{irc_pkg::OP_PUT,   10'd0,    0, 6'd0,   1, 1'b0, BLANK_REPLY}
   };

   logic clock = 1'b0;
   logic reset;

   irc_req_if #(.SLOT_COUNT(SLOTS), .INODE_COUNT(INODES)) req_ch ();
   irc_rsp_if #(.SLOT_COUNT(SLOTS), .INODE_COUNT(INODES), .REF_BITS(REF_BITS)) rsp_ch ();

   inode_refcount_cache #(
      .SLOT_COUNT  (SLOTS),
      .INODE_COUNT (INODES),
      .REF_BITS    (REF_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // shadow copy of the slot table and the allocation bitmap
   logic [INO_W-1:0]    cached_ino  [SLOTS];
   logic [REF_BITS-1:0] cached_refs [SLOTS];
   bit                  inode_taken [INODES];
   int                  inodes_taken;

   reply_type awaited_replies [$];
   reply_type head;
   int        mismatches;
   int        items_sent;
   int        results_taken;
   bit        send_quiet;
   bit        recv_quiet;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         cached_ino[i]  = '0;
         cached_refs[i] = '0;
      end
      inodes_taken = 0;
      mismatches   = 0;
      items_sent   = 0;
      results_taken = 0;
   end

   // live hit first, else the lowest free slot; -1 when the table is full
   function automatic int claim_slot(input logic [INO_W-1:0] ino, output bit claimed);
      int i;
      claimed = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         if (cached_refs[i] != 0 && cached_ino[i] == ino) begin
            if (cached_refs[i] != REF_MAX) cached_refs[i]++;
            return i;
         end
      end
      for (i = 0; i < SLOTS; i++) begin
         if (cached_refs[i] == 0) begin
            cached_refs[i] = 1;
            cached_ino[i]  = ino;
            claimed = 1'b1;
            return i;
         end
      end
      return -1;
   endfunction

   function automatic reply_type slot_reply(input irc_pkg::status_type st, input int s,
                                            input bit fetch, input bit wb, input bit fresh);
      reply_type r;
      r.status = st;
      r.slot   = SLOT_W'(s);
      r.inode  = cached_ino[s];
      r.refs   = cached_refs[s];
      r.fetch  = fetch;
      r.wb     = wb;
      r.fresh  = fresh;
      return r;
   endfunction

   function automatic reply_type cache_step(input logic [1:0] op,
                                            input logic [INO_W-1:0] ino,
                                            input logic [SLOT_W-1:0] sidx);
      reply_type        r;
      int               s;
      int               i;
      bit               claimed;
      logic [INO_W-1:0] new_ino;
      r = BLANK_REPLY;
      case (op)
         irc_pkg::OP_GET: begin
            s = claim_slot(ino, claimed);
            if (s < 0) r.status = irc_pkg::ST_NO_SLOT;
            else r = slot_reply(irc_pkg::ST_OK, s, claimed, 1'b0, 1'b0);
         end
         irc_pkg::OP_PUT: begin
            if (int'(sidx) >= SLOTS) begin
               r.status = irc_pkg::ST_IGNORED;
            end else if (cached_refs[sidx] == 0) begin
               r = slot_reply(irc_pkg::ST_IGNORED, sidx, 1'b0, 1'b0, 1'b0);
            end else begin
               cached_refs[sidx]--;
               r = slot_reply(irc_pkg::ST_OK, sidx, 1'b0, cached_refs[sidx] == 0, 1'b0);
            end
         end
         irc_pkg::OP_ALLOC: begin
            s = -1;
            for (i = INODES - 1; i >= 0; i--)
               if (!inode_taken[i]) s = i;
            if (s < 0) begin
               r.status = irc_pkg::ST_NO_INODE;
            end else begin
               inode_taken[s] = 1'b1;
               inodes_taken++;
               new_ino = INO_W'(s);
               s = claim_slot(new_ino, claimed);
               if (s < 0) r.status = irc_pkg::ST_NO_SLOT;
               else r = slot_reply(irc_pkg::ST_OK, s, 1'b0, 1'b1, 1'b1);
            end
         end
         default: r.status = irc_pkg::ST_IGNORED;
      endcase
      return r;
   endfunction

   function automatic int pick_live_slot();
      int live [$];
      int i;
      for (i = 0; i < SLOTS; i++)
         if (cached_refs[i] != 0) live.push_back(i);
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size() - 1)];
   endfunction

   function automatic void match_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [INO_W-1:0] ino,
                            input logic [SLOT_W-1:0] sidx, input bit typed,
                            input reply_type want);
      int        gap;
      reply_type guess;
      if (items_sent % 64 == 0) send_quiet = ($urandom_range(0, 2) == 0);
      gap = send_quiet ? 0 : $urandom_range(0, 7);
      repeat (gap) @(negedge clock) req_ch.valid <= 1'b0;
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= op;
      req_ch.inode_number <= ino;
      req_ch.slot_index   <= sidx;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      guess = cache_step(op, ino, sidx);
      awaited_replies.push_back(typed ? want : guess);
      items_sent++;
   endtask

   // weights in percent; whatever is left over goes to the unused opcode
   task automatic random_item(input int get_w, input int put_w, input int alloc_w);
      int                roll;
      int                s;
      logic [1:0]        op;
      logic [INO_W-1:0]  ino;
      logic [SLOT_W-1:0] sidx;
      roll = $urandom_range(0, 99);
      ino  = INO_W'($urandom_range(0, INODES - 1));
      sidx = SLOT_W'($urandom_range(0, SLOTS - 1));
      if (roll < get_w) begin
         op = irc_pkg::OP_GET;
         s = pick_live_slot();
         if (s >= 0 && $urandom_range(0, 9) < 6) ino = cached_ino[s];
      end else if (roll < get_w + put_w) begin
         op = irc_pkg::OP_PUT;
         s = pick_live_slot();
         if (s >= 0 && $urandom_range(0, 3) != 0) sidx = SLOT_W'(s);
      end else if (roll < get_w + put_w + alloc_w) begin
         op = irc_pkg::OP_ALLOC;
      end else begin
         op = OP_UNUSED;
      end
      send_item(op, ino, sidx, 1'b0, BLANK_REPLY);
   endtask

   // a get or alloc may still be scanning when the queue runs dry
   task automatic drain();
      @(negedge clock) req_ch.valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
   endtask

   initial begin : rsp_side
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         if (results_taken % 64 == 0) recv_quiet = ($urandom_range(0, 2) == 0);
         stall = recv_quiet ? 0 : $urandom_range(0, 7);
         repeat (stall) @(negedge clock) rsp_ch.ready <= 1'b0;
         @(negedge clock) rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         results_taken++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_replies.size() == 0) begin
            $error("result item with nothing outstanding: status %0d slot %0d",
                   rsp_ch.status, rsp_ch.result_slot);
            mismatches++;
         end else begin
            head = awaited_replies.pop_front();
            match_field("status",       head.status, rsp_ch.status);
            match_field("result_slot",  head.slot,   rsp_ch.result_slot);
            match_field("result_inode", head.inode,  rsp_ch.result_inode);
            match_field("result_refs",  head.refs,   rsp_ch.result_refs);
            match_field("fetch_needed", head.fetch,  rsp_ch.fetch_needed);
            match_field("write_back",   head.wb,     rsp_ch.write_back);
            match_field("fresh_inode",  head.fresh,  rsp_ch.fresh_inode);
         end
      end
   end

   initial begin : stimulus
      int               k;
      logic [INO_W-1:0] ino_k;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.opcode       = '0;
      req_ch.inode_number = '0;
      req_ch.slot_index   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (plan[r]) begin
         for (k = 0; k < plan[r].reps; k++) begin
            ino_k = plan[r].ino + INO_W'(k * plan[r].ino_step);
            send_item(plan[r].op, ino_k, plan[r].sidx, plan[r].typed, plan[r].want);
         end
      end

      repeat (50) random_item(40, 35, 20);
      drain();
      // alloc-heavy until the bitmap runs out
      while (inodes_taken < INODES) random_item(2, 6, 92);
      repeat (30) random_item(40, 35, 20);
      drain();

      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
